// File: design/apusrw_pkg.sv
// ----------------------------------------------------------------------------
// Shadow register writer package
// Types, register numbers and sweep sequence constants for the writer.
// ----------------------------------------------------------------------------
package apusrw_pkg;

  localparam int NUM_REGS_DEF = 24;
  localparam int REG_W = 5;
  localparam int VAL_W = 8;

  localparam logic [REG_W-1:0] PULSE1_HI = 5'h03;
  localparam logic [REG_W-1:0] PULSE2_HI = 5'h07;
  localparam logic [REG_W-1:0] PULSE1_LO = 5'h02;
  localparam logic [REG_W-1:0] PULSE2_LO = 5'h06;
  localparam logic [REG_W-1:0] HI_TO_LO = 5'h01;
  localparam logic [REG_W-1:0] HI_TO_VOL = 5'h02;
  localparam logic [REG_W-1:0] SWEEP_REG = 5'h17;

  localparam logic [VAL_W-1:0] LO_DOWN = 8'h00;
  localparam logic [VAL_W-1:0] LO_UP = 8'hFF;
  localparam logic [VAL_W-1:0] VOL_DOWN = 8'h8F;
  localparam logic [VAL_W-1:0] VOL_UP = 8'h87;
  localparam logic [VAL_W-1:0] SWEEP_VAL = 8'hC0;
  localparam logic [VAL_W-1:0] VOL_RESTORE = 8'h0F;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SINGLE,
    ACT_SWEEP
  } act_t;

  typedef enum logic [1:0] {
    STEP_VOL,
    STEP_SWEEP,
    STEP_RESTORE,
    STEP_LOW
  } step_t;

  typedef struct packed {
    act_t             act;
    logic             down;
    logic [VAL_W-1:0] low;
  } decision_t;

endpackage

// File: design/apu_shadow_register_writer.sv
// ----------------------------------------------------------------------------
// Shadow register writer: a request goes through the input register, then the
// output register. A plain write sustains one request per cycle while out_stall
// is low; a sweep emits five words, one per cycle from the output register unless
// stalled. Reset clears the shadow copy to zero at once and empties both registers.
// ----------------------------------------------------------------------------
module apu_shadow_register_writer #(
  parameter int NUM_REGS = apusrw_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [apusrw_pkg::REG_W-1:0]  reg_index,
  input  logic [apusrw_pkg::VAL_W-1:0]  new_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [apusrw_pkg::REG_W-1:0]  out_reg,
  output logic [apusrw_pkg::VAL_W-1:0]  out_value,
  output logic                          last
);
  import apusrw_pkg::*;

  logic             in_q_valid;
  logic             in_q_type;
  logic [REG_W-1:0] in_q_reg;
  logic [VAL_W-1:0] in_q_value;

  logic             seq_active;
  step_t            seq_step;
  logic [REG_W-1:0] seq_hi;
  logic             seq_down;
  logic [VAL_W-1:0] seq_low;

  logic             out_valid_next;
  logic [REG_W-1:0] out_reg_next;
  logic [VAL_W-1:0] out_value_next;
  logic             last_next;
  logic             seq_active_next;
  step_t            seq_step_next;
  logic [REG_W-1:0] seq_hi_next;
  logic             seq_down_next;
  logic [VAL_W-1:0] seq_low_next;

  logic             out_adv;
  logic             load_ok;
  logic             in_fire;
  logic             consume;
  decision_t        dec;

  assign out_adv = !out_valid || !out_stall;
  assign load_ok = out_adv && !seq_active;
  assign in_stall = in_q_valid && !load_ok;
  assign in_fire = in_valid && !in_stall;
  assign consume = in_q_valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_fire) begin
      in_q_valid <= 1'b1;
    end else if (consume) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_q_type <= req_type;
      in_q_reg <= reg_index;
      in_q_value <= new_value;
    end
  end

  apusrw_shadow #(
    .NUM_REGS (NUM_REGS)
  ) u_shadow (
    .clk       (clk),
    .rst       (rst),
    .upd       (consume),
    .req_type  (in_q_type),
    .reg_index (in_q_reg),
    .new_value (in_q_value),
    .dec       (dec)
  );

  always_comb begin
    out_valid_next = out_valid;
    out_reg_next = out_reg;
    out_value_next = out_value;
    last_next = last;
    seq_active_next = seq_active;
    seq_step_next = seq_step;
    seq_hi_next = seq_hi;
    seq_down_next = seq_down;
    seq_low_next = seq_low;
    if (out_adv) begin
      if (seq_active) begin
        out_valid_next = 1'b1;
        last_next = 1'b0;
        unique case (seq_step)
          STEP_VOL: begin
            out_reg_next = seq_hi - HI_TO_VOL;
            out_value_next = seq_down ? VOL_DOWN : VOL_UP;
            seq_step_next = STEP_SWEEP;
          end
          STEP_SWEEP: begin
            out_reg_next = SWEEP_REG;
            out_value_next = SWEEP_VAL;
            seq_step_next = STEP_RESTORE;
          end
          STEP_RESTORE: begin
            out_reg_next = seq_hi - HI_TO_VOL;
            out_value_next = VOL_RESTORE;
            seq_step_next = STEP_LOW;
          end
          default: begin
            out_reg_next = seq_hi - HI_TO_LO;
            out_value_next = seq_low;
            last_next = 1'b1;
            seq_active_next = 1'b0;
            seq_step_next = STEP_VOL;
          end
        endcase
      end else if (in_q_valid) begin
        unique case (dec.act)
          ACT_SINGLE: begin
            out_valid_next = 1'b1;
            out_reg_next = in_q_reg;
            out_value_next = in_q_value;
            last_next = 1'b1;
          end
          ACT_SWEEP: begin
            out_valid_next = 1'b1;
            out_reg_next = in_q_reg - HI_TO_LO;
            out_value_next = dec.down ? LO_DOWN : LO_UP;
            last_next = 1'b0;
            seq_active_next = 1'b1;
            seq_step_next = STEP_VOL;
            seq_hi_next = in_q_reg;
            seq_down_next = dec.down;
            seq_low_next = dec.low;
          end
          default: begin
            out_valid_next = 1'b0;
          end
        endcase
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq_active <= 1'b0;
      seq_step <= STEP_VOL;
    end else begin
      out_valid <= out_valid_next;
      seq_active <= seq_active_next;
      seq_step <= seq_step_next;
    end
  end

  always_ff @(posedge clk) begin
    out_reg <= out_reg_next;
    out_value <= out_value_next;
    last <= last_next;
    seq_hi <= seq_hi_next;
    seq_down <= seq_down_next;
    seq_low <= seq_low_next;
  end

`ifndef SYNTHESIS
  a_sweep_holds_output: assert property (@(posedge clk) disable iff (rst)
    seq_active |-> out_valid && !last)
    else $error("Sweep in progress without a pending non-final word.");

  a_sweep_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && !out_stall |=> out_valid)
    else $error("Sweep sequence broke off before its final word.");

  a_sweep_word_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && (out_reg == SWEEP_REG) |-> out_value == SWEEP_VAL)
    else $error("Sweep register word carries the wrong value.");
`endif

endmodule

// File: design/apusrw_shadow.sv
// ----------------------------------------------------------------------------
// Shadow register store
// Holds the shadow copy of the chip registers, decides what a request emits
// and applies the resulting shadow updates when the request is consumed.
// ----------------------------------------------------------------------------
module apusrw_shadow #(
  parameter int NUM_REGS = apusrw_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          upd,
  input  logic                          req_type,
  input  logic [apusrw_pkg::REG_W-1:0]  reg_index,
  input  logic [apusrw_pkg::VAL_W-1:0]  new_value,
  output apusrw_pkg::decision_t         dec
);
  import apusrw_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);

  logic [VAL_W-1:0] shadow [NUM_REGS];
  logic             in_range;
  logic [VAL_W-1:0] cur;
  logic [2:0]       old_lo;
  logic [2:0]       new_lo;
  logic             is_hi;
  logic             down;
  logic             up;
  logic [REG_W-1:0] vol_reg;

  assign in_range = ({1'b0, reg_index} < (REG_W + 1)'(NUM_REGS));
  assign cur = shadow[reg_index[IDX_W-1:0]];
  assign old_lo = cur[2:0];
  assign new_lo = new_value[2:0];
  assign is_hi = (reg_index == PULSE1_HI) || (reg_index == PULSE2_HI);
  assign down = ({1'b0, new_lo} + 4'd1) == {1'b0, old_lo};
  assign up = ({1'b0, old_lo} + 4'd1) == {1'b0, new_lo};
  assign vol_reg = reg_index - HI_TO_VOL;

  always_comb begin
    dec.down = down;
    dec.low = (reg_index == PULSE1_HI) ? shadow[IDX_W'(PULSE1_LO)]
                                       : shadow[IDX_W'(PULSE2_LO)];
    if (!in_range) begin
      dec.act = ACT_NONE;
    end else if (req_type) begin
      dec.act = ACT_SINGLE;
    end else if (cur == new_value) begin
      dec.act = ACT_NONE;
    end else if (is_hi && (down || up)) begin
      dec.act = ACT_SWEEP;
    end else begin
      dec.act = ACT_SINGLE;
    end
  end

  // The low period register ends the sweep with its old value, so only the
  // volume, sweep and high period registers change in the shadow.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        shadow[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if ((dec.act == ACT_SWEEP) && (REG_W'(i) == vol_reg)) begin
          shadow[i] <= VOL_RESTORE;
        end
        if ((dec.act == ACT_SWEEP) && (REG_W'(i) == SWEEP_REG)) begin
          shadow[i] <= SWEEP_VAL;
        end
        if ((dec.act != ACT_NONE) && (REG_W'(i) == reg_index)) begin
          shadow[i] <= new_value;
        end
      end
    end
  end

endmodule

// File: verif/apu_shadow_register_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow register writer testbench
// Drives write requests through a table of directed cases and then a random
// stream that leans on the pulse high-period sweeps. Every word from the block
// is compared in order with a local model of the shadow copy. Both sides idle
// at random, and the output side holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module apu_shadow_register_writer_test;
  import apusrw_pkg::*;

  localparam int NUM_REGS = NUM_REGS_DEF;
  localparam int RANDOM_ITEMS = 180;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_AT_WORD = 60;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [REG_W-1:0] addr;
    logic [VAL_W-1:0] value;
    logic             last;
  } chip_write_t;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_SILENT,
    CHECK_ECHO
  } row_check_t;

  typedef struct packed {
    logic             forced;
    logic [REG_W-1:0] idx;
    logic [VAL_W-1:0] value;
    row_check_t       check;
  } stim_row_t;

  localparam int NUM_ROWS = 24;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{1'b0, 5'd0, 8'h00, CHECK_SILENT},
    '{1'b1, 5'd0, 8'h00, CHECK_ECHO},
    '{1'b0, SWEEP_REG, 8'hFF, CHECK_ECHO},
    '{1'b0, 5'(NUM_REGS), 8'hAA, CHECK_SILENT},
    '{1'b1, 5'd31, 8'h55, CHECK_SILENT},
    '{1'b0, 5'd1, 8'h80, CHECK_ECHO},
    '{1'b0, PULSE1_LO, 8'h5A, CHECK_ECHO},
    '{1'b1, PULSE1_HI, 8'h01, CHECK_ECHO},
    '{1'b0, PULSE1_HI, 8'h02, CHECK_MODEL},
    '{1'b0, PULSE1_HI, 8'h01, CHECK_MODEL},
    '{1'b0, PULSE1_HI, 8'h81, CHECK_MODEL},
    '{1'b0, PULSE1_HI, 8'h84, CHECK_MODEL},
    '{1'b0, PULSE2_LO, 8'hA5, CHECK_ECHO},
    '{1'b0, PULSE2_HI, 8'h07, CHECK_MODEL},
    '{1'b0, PULSE2_HI, 8'h00, CHECK_MODEL},
    '{1'b0, PULSE2_HI, 8'h01, CHECK_MODEL},
    '{1'b0, PULSE2_HI, 8'h00, CHECK_MODEL},
    '{1'b0, PULSE2_HI, 8'h00, CHECK_SILENT},
    '{1'b0, SWEEP_REG, 8'hC0, CHECK_MODEL},
    '{1'b1, SWEEP_REG, 8'h00, CHECK_ECHO},
    '{1'b0, 5'd16, 8'h7F, CHECK_ECHO},
    '{1'b0, 5'd8, 8'hFF, CHECK_ECHO},
    '{1'b1, 5'd22, 8'hFF, CHECK_ECHO},
    '{1'b0, 5'd4, 8'h03, CHECK_MODEL}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             req_type = 1'b0;
  logic [REG_W-1:0] reg_index = '0;
  logic [VAL_W-1:0] new_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [REG_W-1:0] out_reg;
  logic [VAL_W-1:0] out_value;
  logic             last;

  logic [VAL_W-1:0] shadow_copy [NUM_REGS];
  chip_write_t      step_writes [$];
  chip_write_t      pending_writes [$];
  int               error_count = 0;
  int               requests_sent = 0;
  int               words_checked = 0;
  int               sweeps_predicted = 0;
  int               random_count = 0;
  int               idle_cycles = 0;
  int               stall_left = 0;

  apu_shadow_register_writer #(
    .NUM_REGS(NUM_REGS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .reg_index(reg_index),
    .new_value(new_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_reg(out_reg),
    .out_value(out_value),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic void emit_write(input logic [REG_W-1:0] addr,
                                     input logic [VAL_W-1:0] value, input logic fin);
    step_writes.push_back('{addr, value, fin});
    shadow_copy[addr] = value;
  endfunction

  function automatic void predict_request(input logic forced, input logic [REG_W-1:0] idx,
                                          input logic [VAL_W-1:0] value);
    int               old_lo;
    int               new_lo;
    logic [VAL_W-1:0] low_save;
    logic             down;
    logic             up;
    step_writes.delete();
    if (idx >= NUM_REGS) return;
    if (!forced && shadow_copy[idx] == value) return;
    if (!forced && (idx == PULSE1_HI || idx == PULSE2_HI)) begin
      old_lo = int'(shadow_copy[idx][2:0]);
      new_lo = int'(value[2:0]);
      low_save = shadow_copy[idx - HI_TO_LO];
      down = (old_lo == new_lo + 1);
      up = (new_lo == old_lo + 1);
      if (down || up) begin
        emit_write(idx - HI_TO_LO, down ? LO_DOWN : LO_UP, 1'b0);
        emit_write(idx - HI_TO_VOL, down ? VOL_DOWN : VOL_UP, 1'b0);
        emit_write(SWEEP_REG, SWEEP_VAL, 1'b0);
        emit_write(idx - HI_TO_VOL, VOL_RESTORE, 1'b0);
        emit_write(idx - HI_TO_LO, low_save, 1'b1);
        shadow_copy[idx] = value;
        sweeps_predicted++;
        return;
      end
    end
    emit_write(idx, value, 1'b1);
  endfunction

  task automatic issue_request(input logic forced, input logic [REG_W-1:0] idx,
                               input logic [VAL_W-1:0] value, input row_check_t check,
                               input int gap, input bit drain_first);
    if (drain_first) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_writes.size() != 0);
    end else if (gap > 0) begin
      in_valid <= 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    req_type <= forced;
    reg_index <= idx;
    new_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    predict_request(forced, idx, value);
    case (check)
      CHECK_ECHO: pending_writes.push_back('{idx, value, 1'b1});
      CHECK_SILENT: ;
      default: begin
        foreach (step_writes[k]) pending_writes.push_back(step_writes[k]);
      end
    endcase
  endtask

  initial begin
    int               pick;
    logic             forced;
    logic [REG_W-1:0] idx;
    logic [VAL_W-1:0] value;
    int               gap;
    foreach (shadow_copy[k]) shadow_copy[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_ROWS[r]) begin
      issue_request(DIRECTED_ROWS[r].forced, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value,
                    DIRECTED_ROWS[r].check, $urandom_range(0, 5), 1'b0);
    end
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      forced = ($urandom_range(0, 4) == 0);
      value = VAL_W'($urandom());
      if (pick < 8) begin
        idx = REG_W'($urandom_range(NUM_REGS, 31));
      end else if (pick < 45) begin
        idx = $urandom_range(0, 1) ? PULSE2_HI : PULSE1_HI;
        value[2:0] = shadow_copy[idx][2:0] + ($urandom_range(0, 1) ? 3'd1 : 3'd7);
      end else if (pick < 55) begin
        idx = REG_W'($urandom_range(0, NUM_REGS - 1));
        value = shadow_copy[idx];
      end else begin
        idx = REG_W'($urandom_range(0, NUM_REGS - 1));
      end
      gap = (random_count >= 60 && random_count < 100) ? 0 : $urandom_range(0, 5);
      issue_request(forced, idx, value, CHECK_MODEL, gap, random_count == 150);
      if (idx < NUM_REGS) random_count++;
    end
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d directed, %0d random in range).",
             requests_sent, NUM_ROWS, random_count);
    $display("Checked %0d words, including %0d predicted sweep sequences.",
             words_checked, sweeps_predicted);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin
    chip_write_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_writes.size() == 0) begin
          report_error($sformatf("unexpected word reg %0d value 0x%02h last %0b",
                                 out_reg, out_value, last));
        end else begin
          want = pending_writes.pop_front();
          if (out_reg !== want.addr)
            report_error($sformatf("out_reg %0d, expected %0d", out_reg, want.addr));
          if (out_value !== want.value)
            report_error($sformatf("out_value 0x%02h, expected 0x%02h", out_value, want.value));
          if (last !== want.last)
            report_error($sformatf("last %0b, expected %0b", last, want.last));
        end
        words_checked++;
        if (words_checked == HOLD_AT_WORD) begin
          stall_left = HOLD_CYCLES;
        end else if (words_checked >= 150 && words_checked < 230) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 5);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without progress.", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// File: files.f
design/apusrw_pkg.sv
design/apusrw_shadow.sv
design/apu_shadow_register_writer.sv
verif/apu_shadow_register_writer_test.sv
